// File: src/sicxe_object_code_encoder_core_macros.svh
// Assertion macros for the checker file of the encoder core.
`ifndef SICXE_OBJECT_CODE_ENCODER_CORE_MACROS_SVH
`define SICXE_OBJECT_CODE_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SICXE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sicxe encoder: implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SICXE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sicxe encoder: next-cycle check failed");

`endif

// File: src/sicxe_enc_pkg.sv
`default_nettype none

package sicxe_enc_pkg;

  // Width of the location counter and the base register.
  localparam int ADDR_WIDTH = 20;
  // Width of the format-3 displacement field.
  localparam int DISP_WIDTH = 12;

  // Fixed widths of the beat fields.
  localparam int TGT_WIDTH  = 20;
  localparam int LOC_WIDTH  = 20;
  localparam int CODE_WIDTH = 32;
  localparam int NBYTES_W   = 3;

  localparam int DISP_HALF = 2 ** (DISP_WIDTH - 1);
  localparam int DISP_MAX  = (2 ** DISP_WIDTH) - 1;

  typedef logic [ADDR_WIDTH-1:0] addr_t;
  typedef logic [DISP_WIDTH-1:0] disp_t;

  typedef enum logic [3:0] {
    KIND_FMT1  = 4'd0,
    KIND_FMT2  = 4'd1,
    KIND_FMT3  = 4'd2,
    KIND_FMT4  = 4'd3,
    KIND_START = 4'd4,
    KIND_BASE  = 4'd5,
    KIND_RESW  = 4'd6,
    KIND_RESB  = 4'd7,
    KIND_BYTE  = 4'd8,
    KIND_END   = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    MODE_SIMPLE   = 2'd0,
    MODE_IMMED    = 2'd1,
    MODE_INDIRECT = 2'd2
  } mode_e;

  // Relative-addressing choice, written into the b and p flag bits.
  typedef enum logic [1:0] {
    REL_NONE = 2'b00,
    REL_PC   = 2'b01,
    REL_BASE = 2'b10
  } rel_e;

  // One parsed source statement.
  typedef struct packed {
    logic [3:0]           kind;
    logic [7:0]           op_byte;
    logic [1:0]           addr_mode;
    logic                 indexed;
    logic [3:0]           reg1;
    logic [3:0]           reg2;
    logic [TGT_WIDTH-1:0] target;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [LOC_WIDTH-1:0]  location;
    logic [CODE_WIDTH-1:0] object_code;
    logic [NBYTES_W-1:0]   code_bytes;
    logic                  status;
  } result_t;

  // State update requested by one statement.
  typedef struct packed {
    addr_t lc_next;
    logic  base_wr;
    addr_t base_next;
  } upd_t;

  // Outcome of the format-3 displacement search.
  typedef struct packed {
    rel_e  rel;
    disp_t disp;
    logic  err;
  } rel_t;

endpackage

`default_nettype wire

// File: src/sicxe_object_code_encoder_core.sv
// Channel   Direction  Handshake                   Beat fields
// in        sink       in_valid_i / in_ready_o     kind, op_byte, addr_mode, indexed,
//                                                  reg1, reg2, target
// out       source     out_valid_o / out_ready_i   location, object_code, code_bytes, status
//
// One statement per cycle sustained while the sink takes each beat. The input register
// holds the statement, the encoder and the location counter update sit between it and
// the output register, so the PC-relative subtraction and its range compare set the
// cycle.
// Reset (rst_ni low, asynchronous) empties both registers and clears the location
// counter, the base register and the base-declared flag.
// A stalled output beat holds the input register; input is refused only while both are
// full and the output beat is not taken.
`default_nettype none

module sicxe_object_code_encoder_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [3:0]                              kind_i,
  input  logic [7:0]                              op_byte_i,
  input  logic [1:0]                              addr_mode_i,
  input  logic                                    indexed_i,
  input  logic [3:0]                              reg1_i,
  input  logic [3:0]                              reg2_i,
  input  logic [sicxe_enc_pkg::TGT_WIDTH-1:0]     target_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [sicxe_enc_pkg::LOC_WIDTH-1:0]     location_o,
  output logic [sicxe_enc_pkg::CODE_WIDTH-1:0]    object_code_o,
  output logic [sicxe_enc_pkg::NBYTES_W-1:0]      code_bytes_o,
  output logic                                    status_o
);
  import sicxe_enc_pkg::*;

  // Input register: one parsed statement waiting to be encoded.
  logic    in_valid_q;
  item_t   item_d;
  item_t   item_q;

  // Assembler state.
  addr_t   lc_q;
  addr_t   base_q;
  logic    base_set_q;

  // Output register.
  logic    out_valid_q;
  result_t res_d;
  result_t res_q;

  upd_t    upd;
  logic    out_load;

  assign item_d = '{kind: kind_i, op_byte: op_byte_i, addr_mode: addr_mode_i,
                    indexed: indexed_i, reg1: reg1_i, reg2: reg2_i, target: target_i};

  // The held statement moves on whenever the output register is empty or being drained,
  // and the input register refills in the same cycle.
  assign out_load   = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || out_load;

  sicxe_enc_format u_format (
    .item_i     (item_q),
    .lc_i       (lc_q),
    .base_i     (base_q),
    .base_set_i (base_set_q),
    .res_o      (res_d),
    .upd_o      (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lc_q        <= '0;
      base_q      <= '0;
      base_set_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // State advances exactly once per statement, as it leaves the input register.
      if (out_load) begin
        lc_q <= upd.lc_next;
        if (upd.base_wr) begin
          base_q     <= upd.base_next;
          base_set_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign location_o    = res_q.location;
  assign object_code_o = res_q.object_code;
  assign code_bytes_o  = res_q.code_bytes;
  assign status_o      = res_q.status;

endmodule

`default_nettype wire

// File: src/sicxe_enc_disp.sv
`default_nettype none

module sicxe_enc_disp (
  input  sicxe_enc_pkg::addr_t lc_i,
  input  sicxe_enc_pkg::addr_t base_i,
  input  logic                 base_set_i,
  input  sicxe_enc_pkg::addr_t tgt_i,
  output sicxe_enc_pkg::rel_t  rel_o
);
  import sicxe_enc_pkg::*;

  localparam addr_t PcStep  = addr_t'(3);
  localparam addr_t PcPosLt = addr_t'(DISP_HALF);
  localparam addr_t PcNegGe = addr_t'((2 ** ADDR_WIDTH) - DISP_HALF);
  localparam addr_t BaseMax = addr_t'(DISP_MAX);

  addr_t pc_disp;
  addr_t base_disp;
  logic  pc_fits;
  logic  base_fits;

  // Both differences wrap at the counter width; the PC one is read as two's complement, the base one as unsigned.
  assign pc_disp   = tgt_i - (lc_i + PcStep);
  assign base_disp = tgt_i - base_i;
  assign pc_fits   = (pc_disp < PcPosLt) || (pc_disp >= PcNegGe);
  assign base_fits = base_set_i && (base_disp <= BaseMax);

  always_comb begin
    rel_o = '{rel: REL_NONE, disp: '0, err: 1'b0};
    priority if (pc_fits) begin
      rel_o.rel  = REL_PC;
      rel_o.disp = pc_disp[DISP_WIDTH-1:0];
    end else if (base_fits) begin
      rel_o.rel  = REL_BASE;
      rel_o.disp = base_disp[DISP_WIDTH-1:0];
    end else begin
      rel_o.err = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: src/sicxe_enc_format.sv
`default_nettype none

module sicxe_enc_format (
  input  sicxe_enc_pkg::item_t   item_i,
  input  sicxe_enc_pkg::addr_t   lc_i,
  input  sicxe_enc_pkg::addr_t   base_i,
  input  logic                   base_set_i,
  output sicxe_enc_pkg::result_t res_o,
  output sicxe_enc_pkg::upd_t    upd_o
);
  import sicxe_enc_pkg::*;

  addr_t      tgt_a;
  addr_t      loc;
  addr_t      adv;
  logic [1:0] ni;
  rel_t       rel;

  assign tgt_a = addr_t'(item_i.target);

  // Unused mode code 3 falls back to simple addressing.
  always_comb begin
    unique case (mode_e'(item_i.addr_mode))
      MODE_IMMED:    ni = 2'b01;
      MODE_INDIRECT: ni = 2'b10;
      default:       ni = 2'b11;
    endcase
  end

  sicxe_enc_disp u_disp (
    .lc_i       (lc_i),
    .base_i     (base_i),
    .base_set_i (base_set_i),
    .tgt_i      (tgt_a),
    .rel_o      (rel)
  );

  always_comb begin
    res_o.object_code = '0;
    res_o.code_bytes  = '0;
    res_o.status      = 1'b0;
    adv               = '0;
    loc               = lc_i;
    upd_o.base_wr     = 1'b0;
    upd_o.base_next   = tgt_a;
    unique case (kind_e'(item_i.kind))
      KIND_FMT1: begin
        res_o.object_code = CODE_WIDTH'(item_i.op_byte);
        res_o.code_bytes  = NBYTES_W'(1);
        adv               = addr_t'(1);
      end
      KIND_FMT2: begin
        res_o.object_code = CODE_WIDTH'({item_i.op_byte, item_i.reg1, item_i.reg2});
        res_o.code_bytes  = NBYTES_W'(2);
        adv               = addr_t'(2);
      end
      KIND_FMT3: begin
        res_o.object_code = CODE_WIDTH'({item_i.op_byte[7:2], ni, item_i.indexed,
                                         rel.rel, 1'b0, rel.disp});
        res_o.code_bytes  = NBYTES_W'(3);
        res_o.status      = rel.err;
        adv               = addr_t'(3);
      end
      KIND_FMT4: begin
        res_o.object_code = CODE_WIDTH'({item_i.op_byte[7:2], ni, item_i.indexed,
                                         REL_NONE, 1'b1, item_i.target});
        res_o.code_bytes  = NBYTES_W'(4);
        adv               = addr_t'(4);
      end
      KIND_START: loc = tgt_a;
      KIND_BASE:  upd_o.base_wr = 1'b1;
      KIND_RESW:  adv = (tgt_a << 1) + tgt_a;
      KIND_RESB,
      KIND_BYTE:  adv = tgt_a;
      default: ;
    endcase
    res_o.location = LOC_WIDTH'(loc);
    upd_o.lc_next  = loc + adv;
  end

endmodule

`default_nettype wire

// File: src/sicxe_enc_checker.sv
`default_nettype none
`include "sicxe_object_code_encoder_core_macros.svh"

module sicxe_enc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [sicxe_enc_pkg::LOC_WIDTH-1:0]  location_o,
  input logic [sicxe_enc_pkg::CODE_WIDTH-1:0] object_code_o,
  input logic [sicxe_enc_pkg::NBYTES_W-1:0]   code_bytes_o,
  input logic                                 status_o
);
  import sicxe_enc_pkg::*;

  // The whole output beat gathered in one vector.
  logic [LOC_WIDTH+CODE_WIDTH+NBYTES_W:0] out_beat;

  assign out_beat = {location_o, object_code_o, code_bytes_o, status_o};

  // A beat that is not taken stays on the port unchanged.
  `SICXE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_beat))

  // An error is only ever reported on a three-byte instruction.
  `SICXE_ASSERT_IMP(a_err_fmt3, clk_i, rst_ni, out_valid_o && status_o, code_bytes_o == 3'd3)

  // Directives carry no object code.
  `SICXE_ASSERT_IMP(a_dir_zero, clk_i, rst_ni, out_valid_o && (code_bytes_o == 3'd0), object_code_o == '0)

  // Input is refused only while a result is held back by the sink.
  `SICXE_ASSERT_IMP(a_no_idle_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind sicxe_object_code_encoder_core sicxe_enc_checker u_sicxe_enc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .location_o    (location_o),
  .object_code_o (object_code_o),
  .code_bytes_o  (code_bytes_o),
  .status_o      (status_o)
);

`default_nettype wire
